/* rtl/tki_pkg.sv */
`timescale 1ns / 1ps

package tki_pkg;

    // Sizing of the slot row and of the item fields.
    localparam int MAX_SLOTS  = 16;
    localparam int INDEX_BITS = 16;
    localparam int SCORE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int KEEP_RESET = 16;
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int K_W        = $clog2(MAX_SLOTS + 1);

    // Contents of one slot.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_BITS-1:0]     item;
        logic                      valid;
    } t_slot;

    // Minimum-search wave handed from cell to cell.
    typedef struct packed {
        logic                      tok;
        logic                      first;
        logic signed [SCORE_W-1:0] score;
        logic [SLOT_W-1:0]         pos;
    } t_search;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic                      wr_en;
        logic [SLOT_W-1:0]         wr_pos;
        logic signed [SCORE_W-1:0] wr_score;
        logic [INDEX_BITS-1:0]     wr_item;
        logic                      shift;
        logic                      clear;
    } t_cell_ctrl;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

endpackage

/* rtl/tki_in_if.sv */
`timescale 1ns / 1ps

interface tki_in_if;
    import tki_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic [INDEX_BITS-1:0]     item_index;
    logic                      final_item;

    modport source (output valid, output score, output item_index, output final_item,
                    input ready);
    modport sink   (input valid, input score, input item_index, input final_item,
                    output ready);
endinterface

/* rtl/tki_out_if.sv */
`timescale 1ns / 1ps

interface tki_out_if;
    import tki_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] slot_score;
    logic [INDEX_BITS-1:0]     slot_item;
    logic                      slot_filled;
    logic                      last_of_run;

    modport source (output valid, output slot_score, output slot_item,
                    output slot_filled, output last_of_run, input ready);
    modport sink   (input valid, input slot_score, input slot_item,
                    input slot_filled, input last_of_run, output ready);
endinterface

/* rtl/tki_cfg_if.sv */
`timescale 1ns / 1ps

interface tki_cfg_if;
    import tki_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] keep_count;

    modport source (output valid, output keep_count, input ready);
    modport sink   (input valid, input keep_count, output ready);
endinterface

/* rtl/tki_cell.sv */
`timescale 1ns / 1ps

module tki_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tki_pkg::SLOT_W-1:0] i_slot_id,
    input  tki_pkg::t_cell_ctrl        i_ctrl,
    input  tki_pkg::t_search           i_search,
    input  tki_pkg::t_slot             i_next,
    output tki_pkg::t_search           o_search,
    output tki_pkg::t_slot             o_slot
);
    import tki_pkg::*;

    t_slot   r_slot, n_slot;
    t_search r_search, n_search;
    logic    take_own;

    // Search step: this cell replaces the running minimum if strictly smaller.
    always_comb begin
        take_own = i_search.first || ($signed(r_slot.score) < $signed(i_search.score));
        n_search = i_search;
        n_search.first = 1'b0;
        if (i_search.tok && take_own) begin
            n_search.score = r_slot.score;
            n_search.pos   = i_slot_id;
        end
    end

    // Slot contents: clear wins, then shift toward the output, then a write.
    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.clear) begin
            n_slot = '0;
        end else if (i_ctrl.shift) begin
            n_slot = i_next;
        end else if (i_ctrl.wr_en && (i_ctrl.wr_pos == i_slot_id)) begin
            n_slot.score = i_ctrl.wr_score;
            n_slot.item  = i_ctrl.wr_item;
            n_slot.valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= '0;
            r_search.tok <= 1'b0;
        end else begin
            r_slot       <= n_slot;
            r_search.tok <= n_search.tok;
        end
        r_search.first <= n_search.first;
        r_search.score <= n_search.score;
        r_search.pos   <= n_search.pos;
    end

    assign o_search = r_search;
    assign o_slot   = r_slot;

endmodule

/* rtl/top_k_index_tracker.sv */
`timescale 1ns / 1ps
// A candidate is searched by a wave that walks the row of k slot cells one cell per cycle;
// on a final item the k slots are then shifted out one by one through the output register.
// A new item is accepted only in the idle state, after the search of the last one and any
// output run that it started; one slot is shifted out of the row per cycle while the output
// does not stall.
// Reset (synchronous, active low) clears every slot, sets k to 16 and drops all valids.
module top_k_index_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tki_cfg_if.sink    i_cfg,
    tki_in_if.sink     i_cand,
    tki_out_if.source  o_slot
);
    import tki_pkg::*;

    t_state                    r_state, n_state;
    logic [COUNT_W-1:0]        r_keep_count;
    logic signed [SCORE_W-1:0] r_cand_score;
    logic [INDEX_BITS-1:0]     r_cand_item;
    logic                      r_cand_final;
    logic [SLOT_W-1:0]         r_emit_cnt, n_emit_cnt;

    logic                      r_out_valid;
    t_slot                     r_out_slot;
    logic                      r_out_last;

    logic [K_W-1:0]            act_k;
    logic [SLOT_W-1:0]         last_idx;
    logic                      accept;
    logic                      done;
    logic                      out_load;
    logic                      emit_last;
    logic                      wave_busy;
    t_search                   min_res;
    t_cell_ctrl                ctrl;

    t_search                   srch_in  [MAX_SLOTS];
    t_search                   srch_out [MAX_SLOTS];
    t_slot                     slot_in  [MAX_SLOTS];
    t_slot                     slot_out [MAX_SLOTS];

    // A search wave may still be travelling through the cells past the last active one.
    always_comb begin
        wave_busy = 1'b0;
        for (int g = 0; g < MAX_SLOTS; g++) begin
            wave_busy = wave_busy | srch_out[g].tok;
        end
    end

    // Configuration register, written only while idle with an empty search row, so that a
    // stray wave cannot end a later search early when k grows.
    assign i_cfg.ready = (r_state == S_IDLE) && !wave_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= COUNT_W'(KEEP_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_keep_count <= i_cfg.keep_count;
        end
    end

    // Active slot count, clamped to 1..MAX_SLOTS.
    always_comb begin
        if (r_keep_count == '0) begin
            act_k = K_W'(1);
        end else if (32'(r_keep_count) > 32'(MAX_SLOTS)) begin
            act_k = K_W'(MAX_SLOTS);
        end else begin
            act_k = K_W'(r_keep_count);
        end
        last_idx = SLOT_W'(act_k - K_W'(1));
    end

    // Input handshake and candidate capture.
    assign i_cand.ready = (r_state == S_IDLE);
    assign accept       = i_cand.valid && i_cand.ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand_score <= i_cand.score;
            r_cand_item  <= i_cand.item_index;
            r_cand_final <= i_cand.final_item;
        end
    end

    // The search wave leaves the last active cell with the minimum and its slot.
    assign min_res   = srch_out[last_idx];
    assign done      = (r_state == S_SEARCH) && min_res.tok;
    assign out_load  = (r_state == S_EMIT) && (!r_out_valid || o_slot.ready);
    assign emit_last = (r_emit_cnt == last_idx);

    always_comb begin
        ctrl.wr_en    = done && ($signed(r_cand_score) > $signed(min_res.score));
        ctrl.wr_pos   = min_res.pos;
        ctrl.wr_score = r_cand_score;
        ctrl.wr_item  = r_cand_item;
        ctrl.shift    = out_load && !emit_last;
        ctrl.clear    = out_load && emit_last;
    end

    // Row of slot cells; the wave enters at cell 0, slots drain toward cell 0.
    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign srch_in[g] = '{tok: accept, first: 1'b1, score: '0, pos: '0};
        end else begin : g_body
            assign srch_in[g] = srch_out[g-1];
        end
        if (g == MAX_SLOTS - 1) begin : g_tail
            assign slot_in[g] = '0;
        end else begin : g_link
            assign slot_in[g] = slot_out[g+1];
        end

        tki_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_slot_id (SLOT_W'(g)),
            .i_ctrl    (ctrl),
            .i_search  (srch_in[g]),
            .i_next    (slot_in[g]),
            .o_search  (srch_out[g]),
            .o_slot    (slot_out[g])
        );
    end

    // Controller.
    always_comb begin
        n_state    = r_state;
        n_emit_cnt = r_emit_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (done) begin
                    n_emit_cnt = '0;
                    n_state    = r_cand_final ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_emit_cnt = r_emit_cnt + SLOT_W'(1);
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_emit_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    // Output register, loaded from the head cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_slot.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_slot <= slot_out[0];
            r_out_last <= emit_last;
        end
    end

    assign o_slot.valid       = r_out_valid;
    assign o_slot.slot_score  = r_out_slot.score;
    assign o_slot.slot_item   = r_out_slot.item;
    assign o_slot.slot_filled = r_out_slot.valid;
    assign o_slot.last_of_run = r_out_last;

endmodule
